FILE: hdl/bthin_pkg.sv
// Shared constants, types and the pixel deletion rule for the thinning block.
package bthin_pkg;

   localparam int MaxWidth   = 256;
   localparam int MaxHeight  = 256;
   localparam int CoordW     = $clog2(MaxWidth);
   localparam int AddrW      = $clog2(MaxWidth * MaxHeight);
   localparam int StoreDepth = MaxWidth * MaxHeight;
   localparam int PosW       = AddrW + 1;
   localparam int DimW       = CoordW + 1;
   localparam int CsrIdxW    = 3;

   localparam logic [CsrIdxW-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_ROI_TOP      = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_ROI_LEFT     = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_ROI_BOTTOM   = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_ROI_RIGHT    = 3'd5;

   localparam logic [1:0] NPH_TOTAL = 2'd0;
   localparam logic [1:0] NPH_INIT  = 2'd1;
   localparam logic [1:0] NPH_DIV   = 2'd2;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_NORM     = 7'b0000010,
      ST_MARK_RD  = 7'b0000100,
      ST_MARK_WR  = 7'b0001000,
      ST_APPLY_RD = 7'b0010000,
      ST_APPLY_WR = 7'b0100000,
      ST_PASS_END = 7'b1000000
   } state_type;

   // ring holds the neighbours clockwise from the north-west corner: nw, n, ne, e, se, s, sw, w (P9, then P2..P8)
   function automatic logic zs_delete(input logic [7:0] ring, input logic pass);
      logic [3:0] sum;
      logic [3:0] trans;
      logic       p1;
      logic       p2;
      sum   = '0;
      trans = '0;
      for (int k = 0; k < 8; k++) begin
         sum = sum + {3'd0, ring[k]};
         if (!ring[k] && ring[(k + 1) % 8]) begin
            trans = trans + 4'd1;
         end
      end
      if (!pass) begin
         p1 = ring[1] & ring[3] & ring[5];
         p2 = ring[3] & ring[5] & ring[7];
      end else begin
         p1 = ring[1] & ring[3] & ring[7];
         p2 = ring[1] & ring[5] & ring[7];
      end
      return (trans == 4'd1) && (sum >= 4'd2) && (sum <= 4'd6) && !p1 && !p2;
   endfunction

endpackage

FILE: hdl/bthin_req_if.sv
// Request channel: load or read one pixel.
interface bthin_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] pixel_value;

   modport source (output valid, output kind, output pixel_value, input ready);
   modport sink (input valid, input kind, input pixel_value, output ready);
endinterface

FILE: hdl/bthin_rsp_if.sv
// Response channel: one skeleton pixel per read request.
interface bthin_rsp_if;
   logic valid;
   logic ready;
   logic skeleton_bit;
   logic in_region;
   logic last_pixel;

   modport source (output valid, output skeleton_bit, output in_region, output last_pixel,
                   input ready);
   modport sink (input valid, input skeleton_bit, input in_region, input last_pixel,
                 output ready);
endinterface

FILE: hdl/bthin_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bthin_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: hdl/binary_image_thinning_top.sv
// Zhang-Suen thinning block: top level with frame store, sequencer and readout.
//
// Loads are taken one per cycle while the block is idle and no read response is pending.
// A read request is answered through the registered frame store read and the response
// register, and the next request is taken once the response has left. After the last pixel
// of a frame the block thins the region of interest, if it is not empty: each sub-pass walks
// the region pixels (nine reads through the single read port of the shared frame store for
// the neighbourhood, one mark write, then a mark read and an optional clear), and sub-passes
// repeat until a full iteration deletes nothing. After every register write the block
// recomputes the frame size and the row/column of the load and read positions with a bit-serial divider.
module binary_image_thinning_top (
   input  logic                          clock,
   input  logic                          reset,
   bthin_req_if.sink                     req_chan,
   bthin_rsp_if.source                   rsp_chan,
   input  logic                          csr_we,
   input  logic [bthin_pkg::CsrIdxW-1:0] csr_index,
   input  logic [bthin_pkg::DimW-1:0]    csr_wdata
);
   localparam int CW = bthin_pkg::CoordW;
   localparam int DW = bthin_pkg::DimW;
   localparam int PW = bthin_pkg::PosW;
   localparam int AW = bthin_pkg::AddrW;

   bthin_pkg::state_type state_ff, state_in;

   logic [DW-1:0] fw_ff, fw_in, fh_ff, fh_in;
   logic [CW-1:0] rt_ff, rt_in, rl_ff, rl_in, rb_ff, rb_in, rr_ff, rr_in;
   logic [PW-1:0] tot_ff, tot_in;

   logic [PW-1:0] ld_raw_ff, ld_raw_in, ld_lin_ff, ld_lin_in;
   logic [CW-1:0] ld_row_ff, ld_row_in, ld_col_ff, ld_col_in;
   logic [PW-1:0] rd_raw_ff, rd_raw_in, rd_lin_ff, rd_lin_in;
   logic [CW-1:0] rd_row_ff, rd_row_in, rd_col_ff, rd_col_in;

   logic [1:0]            nph_ff, nph_in;
   logic                  nsel_ff, nsel_in;
   logic [$clog2(PW)-1:0] ncnt_ff, ncnt_in;
   logic [PW-1:0]         npos_ff, npos_in, nquo_ff, nquo_in;
   logic [DW-1:0]         nrem_ff, nrem_in;

   logic [CW-1:0] trow_ff, trow_in, tcol_ff, tcol_in;
   logic [3:0]    kcnt_ff, kcnt_in;
   logic [8:0]    nb_ff, nb_in;
   logic          pass_ff, pass_in, dany_ff, dany_in;

   logic rd_pend_ff, rd_pend_in, pend_inr_ff, pend_inr_in, pend_last_ff, pend_last_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_bit_ff, rsp_bit_in;
   logic rsp_inr_ff, rsp_inr_in, rsp_last_ff, rsp_last_in;

   // effective frame size and clamped region
   logic [DW-1:0] w_eff, h_eff, wm2, hm2;
   logic [CW-1:0] reg_t, reg_l, reg_b, reg_r;
   logic          roi_ok;

   always_comb begin
      w_eff = (fw_ff < DW'(3)) ? DW'(3) : ((fw_ff > DW'(bthin_pkg::MaxWidth)) ?
              DW'(bthin_pkg::MaxWidth) : fw_ff);
      h_eff = (fh_ff < DW'(3)) ? DW'(3) : ((fh_ff > DW'(bthin_pkg::MaxHeight)) ?
              DW'(bthin_pkg::MaxHeight) : fh_ff);
      wm2   = w_eff - DW'(2);
      hm2   = h_eff - DW'(2);
      reg_t = (rt_ff == '0) ? CW'(1) : rt_ff;
      reg_l = (rl_ff == '0) ? CW'(1) : rl_ff;
      reg_b = ({1'b0, rb_ff} > hm2) ? hm2[CW-1:0] : rb_ff;
      reg_r = ({1'b0, rr_ff} > wm2) ? wm2[CW-1:0] : rr_ff;
      roi_ok = (reg_t <= reg_b) && (reg_l <= reg_r);
   end

   // frame store and delete marks
   logic          img_we, img_wdata, img_rdata;
   logic [AW-1:0] img_waddr, img_raddr;
   logic          mk_we, mk_wdata, mk_rdata;
   logic [AW-1:0] tidx, naddr;

   bthin_ram #(.WIDTH(1), .DEPTH(bthin_pkg::StoreDepth)) u_img (
      .clock (clock),
      .we    (img_we),
      .waddr (img_waddr),
      .wdata (img_wdata),
      .raddr (img_raddr),
      .rdata (img_rdata)
   );

   bthin_ram #(.WIDTH(1), .DEPTH(bthin_pkg::StoreDepth)) u_marks (
      .clock (clock),
      .we    (mk_we),
      .waddr (tidx),
      .wdata (mk_wdata),
      .raddr (tidx),
      .rdata (mk_rdata)
   );

   // neighbourhood walk: center first, then the ring clockwise from north-west
   logic [CW-1:0] nrow, ncol;
   always_comb begin
      nrow = trow_ff;
      ncol = tcol_ff;
      unique case (kcnt_ff)
         4'd1: begin nrow = trow_ff - CW'(1); ncol = tcol_ff - CW'(1); end
         4'd2: begin nrow = trow_ff - CW'(1); end
         4'd3: begin nrow = trow_ff - CW'(1); ncol = tcol_ff + CW'(1); end
         4'd4: begin ncol = tcol_ff + CW'(1); end
         4'd5: begin nrow = trow_ff + CW'(1); ncol = tcol_ff + CW'(1); end
         4'd6: begin nrow = trow_ff + CW'(1); end
         4'd7: begin nrow = trow_ff + CW'(1); ncol = tcol_ff - CW'(1); end
         4'd8: begin ncol = tcol_ff - CW'(1); end
         default: begin end
      endcase
      tidx  = {trow_ff, tcol_ff};
      naddr = {nrow, ncol};
   end

   logic req_acc, ld_acc, rd_acc, tlast, pix_del, inr;
   logic [DW:0]   div_sh;
   logic [DW-1:0] div_rem;
   logic [PW-1:0] div_quo, nsrc;

   assign req_chan.ready = (state_ff == bthin_pkg::ST_IDLE) && !rd_pend_ff && !rsp_valid_ff;
   assign req_acc = req_chan.valid && req_chan.ready;
   assign ld_acc  = req_acc && !req_chan.kind;
   assign rd_acc  = req_acc && req_chan.kind;
   assign tlast   = (tcol_ff == reg_r) && (trow_ff == reg_b);
   assign pix_del = nb_ff[0] && bthin_pkg::zs_delete(nb_ff[8:1], pass_ff);
   assign inr = roi_ok && ({1'b0, rd_row_ff} + DW'(1) >= {1'b0, reg_t}) &&
                ({1'b0, rd_row_ff} <= {1'b0, reg_b} + DW'(1)) &&
                ({1'b0, rd_col_ff} + DW'(1) >= {1'b0, reg_l}) &&
                ({1'b0, rd_col_ff} <= {1'b0, reg_r} + DW'(1));

   always_comb begin
      nsrc    = nsel_ff ? rd_raw_ff : ld_raw_ff;
      div_sh  = {nrem_ff, npos_ff[ncnt_ff]};
      div_quo = nquo_ff;
      if (div_sh >= {1'b0, w_eff}) begin
         div_rem          = DW'(div_sh - {1'b0, w_eff});
         div_quo[ncnt_ff] = 1'b1;
      end else begin
         div_rem = div_sh[DW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      fw_in = fw_ff; fh_in = fh_ff;
      rt_in = rt_ff; rl_in = rl_ff; rb_in = rb_ff; rr_in = rr_ff;
      tot_in = tot_ff;
      ld_raw_in = ld_raw_ff; ld_lin_in = ld_lin_ff; ld_row_in = ld_row_ff; ld_col_in = ld_col_ff;
      rd_raw_in = rd_raw_ff; rd_lin_in = rd_lin_ff; rd_row_in = rd_row_ff; rd_col_in = rd_col_ff;
      nph_in = nph_ff; nsel_in = nsel_ff; ncnt_in = ncnt_ff;
      npos_in = npos_ff; nquo_in = nquo_ff; nrem_in = nrem_ff;
      trow_in = trow_ff; tcol_in = tcol_ff; kcnt_in = kcnt_ff; nb_in = nb_ff;
      pass_in = pass_ff; dany_in = dany_ff;
      rd_pend_in = 1'b0; pend_inr_in = pend_inr_ff; pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_bit_in = rsp_bit_ff; rsp_inr_in = rsp_inr_ff; rsp_last_in = rsp_last_ff;
      img_we = 1'b0; img_waddr = tidx; img_wdata = 1'b0;
      img_raddr = {rd_row_ff, rd_col_ff};
      mk_we = 1'b0; mk_wdata = pix_del;

      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_bit_in   = img_rdata;
         rsp_inr_in   = pend_inr_ff;
         rsp_last_in  = pend_last_ff;
      end

      unique case (state_ff)
         bthin_pkg::ST_IDLE: begin
            if (ld_acc) begin
               img_we    = 1'b1;
               img_waddr = {ld_row_ff, ld_col_ff};
               img_wdata = (req_chan.pixel_value == '0);
               if (ld_lin_ff == tot_ff - PW'(1)) begin
                  ld_lin_in = '0; ld_row_in = '0; ld_col_in = '0;
                  pass_in = 1'b0; dany_in = 1'b0;
                  if (roi_ok) begin
                     trow_in = reg_t; tcol_in = reg_l; kcnt_in = '0;
                     state_in = bthin_pkg::ST_MARK_RD;
                  end
               end else begin
                  ld_lin_in = ld_lin_ff + PW'(1);
                  if ({1'b0, ld_col_ff} + DW'(1) == w_eff) begin
                     ld_col_in = '0;
                     ld_row_in = ld_row_ff + CW'(1);
                  end else begin
                     ld_col_in = ld_col_ff + CW'(1);
                  end
               end
               ld_raw_in = ld_lin_in;
            end
            if (rd_acc) begin
               rd_pend_in   = 1'b1;
               pend_inr_in  = inr;
               pend_last_in = (rd_lin_ff == tot_ff - PW'(1));
               if (rd_lin_ff == tot_ff - PW'(1)) begin
                  rd_lin_in = '0; rd_row_in = '0; rd_col_in = '0;
               end else begin
                  rd_lin_in = rd_lin_ff + PW'(1);
                  if ({1'b0, rd_col_ff} + DW'(1) == w_eff) begin
                     rd_col_in = '0;
                     rd_row_in = rd_row_ff + CW'(1);
                  end else begin
                     rd_col_in = rd_col_ff + CW'(1);
                  end
               end
               rd_raw_in = rd_lin_in;
            end
         end
         bthin_pkg::ST_NORM: begin
            unique case (nph_ff)
               bthin_pkg::NPH_TOTAL: begin
                  tot_in  = PW'(w_eff * h_eff);
                  nsel_in = 1'b0;
                  nph_in  = bthin_pkg::NPH_INIT;
               end
               bthin_pkg::NPH_INIT: begin
                  npos_in = (nsrc >= tot_ff) ? '0 : nsrc;
                  nrem_in = '0;
                  nquo_in = '0;
                  ncnt_in = $clog2(PW)'(PW - 1);
                  nph_in  = bthin_pkg::NPH_DIV;
               end
               default: begin
                  nrem_in = div_rem;
                  nquo_in = div_quo;
                  ncnt_in = ncnt_ff - 1'b1;
                  if (ncnt_ff == '0) begin
                     if (!nsel_ff) begin
                        ld_lin_in = npos_ff;
                        ld_row_in = div_quo[CW-1:0];
                        ld_col_in = div_rem[CW-1:0];
                        nsel_in   = 1'b1;
                        nph_in    = bthin_pkg::NPH_INIT;
                     end else begin
                        rd_lin_in = npos_ff;
                        rd_row_in = div_quo[CW-1:0];
                        rd_col_in = div_rem[CW-1:0];
                        state_in  = bthin_pkg::ST_IDLE;
                     end
                  end
               end
            endcase
         end
         bthin_pkg::ST_MARK_RD: begin
            img_raddr = naddr;
            if (kcnt_ff != '0) begin
               nb_in[kcnt_ff - 4'd1] = img_rdata;
            end
            if (kcnt_ff == 4'd9) begin
               state_in = bthin_pkg::ST_MARK_WR;
            end else begin
               kcnt_in = kcnt_ff + 4'd1;
            end
         end
         bthin_pkg::ST_MARK_WR: begin
            mk_we   = 1'b1;
            dany_in = dany_ff | pix_del;
            kcnt_in = '0;
            if (tcol_ff == reg_r) begin
               tcol_in = reg_l;
               trow_in = trow_ff + CW'(1);
            end else begin
               tcol_in = tcol_ff + CW'(1);
            end
            if (tlast) begin
               trow_in  = reg_t;
               tcol_in  = reg_l;
               state_in = bthin_pkg::ST_APPLY_RD;
            end else begin
               state_in = bthin_pkg::ST_MARK_RD;
            end
         end
         bthin_pkg::ST_APPLY_RD: begin
            state_in = bthin_pkg::ST_APPLY_WR;
         end
         bthin_pkg::ST_APPLY_WR: begin
            img_we = mk_rdata;
            if (tcol_ff == reg_r) begin
               tcol_in = reg_l;
               trow_in = trow_ff + CW'(1);
            end else begin
               tcol_in = tcol_ff + CW'(1);
            end
            state_in = tlast ? bthin_pkg::ST_PASS_END : bthin_pkg::ST_APPLY_RD;
         end
         default: begin
            // sub-pass done; stop after a full iteration with no deletion
            trow_in = reg_t;
            tcol_in = reg_l;
            kcnt_in = '0;
            if (pass_ff && !dany_ff) begin
               pass_in  = 1'b0;
               state_in = bthin_pkg::ST_IDLE;
            end else begin
               if (pass_ff) begin
                  dany_in = 1'b0;
               end
               pass_in  = !pass_ff;
               state_in = bthin_pkg::ST_MARK_RD;
            end
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            bthin_pkg::CSR_FRAME_WIDTH:  fw_in = csr_wdata;
            bthin_pkg::CSR_FRAME_HEIGHT: fh_in = csr_wdata;
            bthin_pkg::CSR_ROI_TOP:      rt_in = csr_wdata[CW-1:0];
            bthin_pkg::CSR_ROI_LEFT:     rl_in = csr_wdata[CW-1:0];
            bthin_pkg::CSR_ROI_BOTTOM:   rb_in = csr_wdata[CW-1:0];
            bthin_pkg::CSR_ROI_RIGHT:    rr_in = csr_wdata[CW-1:0];
            default: begin end
         endcase
         nph_in   = bthin_pkg::NPH_TOTAL;
         state_in = bthin_pkg::ST_NORM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bthin_pkg::ST_IDLE;
         fw_ff <= DW'(bthin_pkg::MaxWidth);
         fh_ff <= DW'(bthin_pkg::MaxHeight);
         rt_ff <= CW'(1);
         rl_ff <= CW'(1);
         rb_ff <= CW'(254);
         rr_ff <= CW'(254);
         tot_ff <= PW'(bthin_pkg::StoreDepth);
         ld_raw_ff <= '0; ld_lin_ff <= '0; ld_row_ff <= '0; ld_col_ff <= '0;
         rd_raw_ff <= '0; rd_lin_ff <= '0; rd_row_ff <= '0; rd_col_ff <= '0;
         nph_ff <= bthin_pkg::NPH_TOTAL;
         nsel_ff <= 1'b0;
         kcnt_ff <= '0;
         pass_ff <= 1'b0;
         dany_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fw_ff <= fw_in; fh_ff <= fh_in;
         rt_ff <= rt_in; rl_ff <= rl_in; rb_ff <= rb_in; rr_ff <= rr_in;
         tot_ff <= tot_in;
         ld_raw_ff <= ld_raw_in; ld_lin_ff <= ld_lin_in;
         ld_row_ff <= ld_row_in; ld_col_ff <= ld_col_in;
         rd_raw_ff <= rd_raw_in; rd_lin_ff <= rd_lin_in;
         rd_row_ff <= rd_row_in; rd_col_ff <= rd_col_in;
         nph_ff <= nph_in;
         nsel_ff <= nsel_in;
         kcnt_ff <= kcnt_in;
         pass_ff <= pass_in;
         dany_ff <= dany_in;
         rd_pend_ff <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ncnt_ff <= ncnt_in;
      npos_ff <= npos_in;
      nquo_ff <= nquo_in;
      nrem_ff <= nrem_in;
      trow_ff <= trow_in;
      tcol_ff <= tcol_in;
      nb_ff <= nb_in;
      pend_inr_ff <= pend_inr_in;
      pend_last_ff <= pend_last_in;
      rsp_bit_ff <= rsp_bit_in;
      rsp_inr_ff <= rsp_inr_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.skeleton_bit = rsp_bit_ff;
   assign rsp_chan.in_region    = rsp_inr_ff;
   assign rsp_chan.last_pixel   = rsp_last_ff;
endmodule

FILE: hdl/bthin_chk.sv
// Port-level checks for the thinning block, bound to the top level.
module bthin_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_kind,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_skeleton_bit,
   input logic       rsp_in_region,
   input logic       rsp_last_pixel
);
   // a read request raises rsp_valid once it has passed the pending-read and response registers
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind) |-> ##2 rsp_valid)
      else $error("read request not answered on time");

   // no new request while a response is still waiting
   a_one_outstanding: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");

   // a load never produces a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_kind && !rsp_valid) |=> ##1 !rsp_valid)
      else $error("response after load request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_skeleton_bit) &&
         $stable(rsp_in_region) && $stable(rsp_last_pixel)))
      else $error("stalled response changed");
endmodule

bind binary_image_thinning_top bthin_chk u_bthin_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_kind         (req_chan.kind),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_skeleton_bit (rsp_chan.skeleton_bit),
   .rsp_in_region    (rsp_chan.in_region),
   .rsp_last_pixel   (rsp_chan.last_pixel)
);

FILE: sim/tb.sv
// Self-checking testbench for the binary image thinning block.
module tb;
   import bthin_pkg::*;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;
   localparam int   WATCHDOG_LIMIT = 200000;
   localparam int   SETTLE_CYCLES  = 300;
   localparam int   ITEM_TARGET    = 1650;

   typedef struct packed {
      logic       kind;
      logic [7:0] pixel_value;
   } pixel_req_t;

   typedef struct packed {
      logic skeleton_bit;
      logic in_region;
      logic last_pixel;
   } pixel_rsp_t;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CsrIdxW-1:0]   csr_index;
   logic [DimW-1:0]      csr_wdata;

   bthin_req_if req_chan ();
   bthin_rsp_if rsp_chan ();

   binary_image_thinning_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pixel_req_t req_pending[$];
   pixel_rsp_t skel_expected[$];
   int         error_count;
   int         items_queued;
   int         rsp_seen;

   // frame model state
   bit         frame_bits[StoreDepth];
   bit         mark_bits[StoreDepth];
   int         width_reg, height_reg;
   int         top_reg, left_reg, bottom_reg, right_reg;
   int         load_pos, read_pos;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_dim(input int v, input int mx);
      return (v < 3) ? 3 : ((v > mx) ? mx : v);
   endfunction

   function automatic bit clamp_region(output int t, output int l, output int b, output int r);
      int w;
      int h;
      w = clamp_dim(width_reg, MaxWidth);
      h = clamp_dim(height_reg, MaxHeight);
      t = (top_reg < 1) ? 1 : top_reg;
      l = (left_reg < 1) ? 1 : left_reg;
      b = (bottom_reg > h - 2) ? h - 2 : bottom_reg;
      r = (right_reg > w - 2) ? w - 2 : right_reg;
      return (t <= b) && (l <= r);
   endfunction

   function automatic bit pix_at(input int row, input int col);
      return frame_bits[(row * MaxWidth + col) % StoreDepth];
   endfunction

   function automatic int mark_and_delete(input int t, input int l, input int b, input int r,
                                          input bit second);
      int         cnt;
      int         idx;
      int         sum;
      int         trans;
      logic [7:0] ring;
      bit         p1;
      bit         p2;
      cnt = 0;
      for (int row = t; row <= b; row++) begin
         for (int col = l; col <= r; col++) begin
            idx = (row * MaxWidth + col) % StoreDepth;
            mark_bits[idx] = 1'b0;
            if (pix_at(row, col)) begin
               ring = {pix_at(row, col - 1), pix_at(row + 1, col - 1), pix_at(row + 1, col),
                       pix_at(row + 1, col + 1), pix_at(row, col + 1), pix_at(row - 1, col + 1),
                       pix_at(row - 1, col), pix_at(row - 1, col - 1)};
               sum = 0;
               trans = 0;
               for (int k = 0; k < 8; k++) begin
                  sum += ring[k];
                  if (!ring[k] && ring[(k + 1) % 8]) trans++;
               end
               if (!second) begin
                  p1 = ring[1] & ring[3] & ring[5];
                  p2 = ring[3] & ring[5] & ring[7];
               end else begin
                  p1 = ring[1] & ring[3] & ring[7];
                  p2 = ring[1] & ring[5] & ring[7];
               end
               mark_bits[idx] = (trans == 1) && (sum >= 2) && (sum <= 6) && !p1 && !p2;
               cnt += mark_bits[idx];
            end
         end
      end
      for (int row = t; row <= b; row++) begin
         for (int col = l; col <= r; col++) begin
            idx = (row * MaxWidth + col) % StoreDepth;
            if (mark_bits[idx]) frame_bits[idx] = 1'b0;
            mark_bits[idx] = 1'b0;
         end
      end
      return cnt;
   endfunction

   function automatic void thin_frame();
      int t, l, b, r;
      bit second;
      bit removed;
      if (!clamp_region(t, l, b, r)) return;
      second = 1'b0;
      removed = 1'b0;
      forever begin
         if (mark_and_delete(t, l, b, r, second) > 0) removed = 1'b1;
         if (second) begin
            if (!removed) break;
            removed = 1'b0;
         end
         second = ~second;
      end
   endfunction

   function automatic void predict_request(input pixel_req_t rq);
      int w, h, total, row, col;
      int t, l, b, r;
      pixel_rsp_t rs;
      w = clamp_dim(width_reg, MaxWidth);
      h = clamp_dim(height_reg, MaxHeight);
      total = w * h;
      if (rq.kind == KIND_LOAD) begin
         if (load_pos >= total) load_pos = 0;
         row = load_pos / w;
         col = load_pos % w;
         frame_bits[(row * MaxWidth + col) % StoreDepth] = (rq.pixel_value == 8'd0);
         if (load_pos == total - 1) begin
            thin_frame();
            load_pos = 0;
         end else begin
            load_pos++;
         end
      end else begin
         if (read_pos >= total) read_pos = 0;
         row = read_pos / w;
         col = read_pos % w;
         rs.in_region = 1'b0;
         if (clamp_region(t, l, b, r))
            rs.in_region = (row + 1 >= t) && (row <= b + 1) && (col + 1 >= l) && (col <= r + 1);
         rs.skeleton_bit = pix_at(row, col);
         rs.last_pixel = (read_pos == total - 1);
         skel_expected.push_back(rs);
         read_pos = (read_pos == total - 1) ? 0 : read_pos + 1;
      end
   endfunction

   // request driver
   int send_gap;
   always @(posedge clock) begin
      pixel_req_t nxt;
      logic       nvalid;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.kind <= KIND_LOAD;
         req_chan.pixel_value <= 8'd0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_request('{kind: req_chan.kind, pixel_value: req_chan.pixel_value});
         if (!req_chan.valid || req_chan.ready) begin
            nvalid = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (req_pending.size() > 0) begin
               nxt = req_pending.pop_front();
               nvalid = 1'b1;
               req_chan.kind <= nxt.kind;
               req_chan.pixel_value <= nxt.pixel_value;
               case ($urandom_range(0, 99)) inside
                  [0:69]:  send_gap = 0;
                  [70:94]: send_gap = $urandom_range(1, 3);
                  default: send_gap = $urandom_range(20, 60);
               endcase
            end
            req_chan.valid <= nvalid;
         end
      end
   end

   // response monitor
   int  rcv_hold;
   bit  pressure_done;
   always @(posedge clock) begin
      pixel_rsp_t got;
      pixel_rsp_t want;
      logic       nready;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rcv_hold = 0;
         pressure_done = 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{skeleton_bit: rsp_chan.skeleton_bit, in_region: rsp_chan.in_region,
                    last_pixel: rsp_chan.last_pixel};
            rsp_seen++;
            if (skel_expected.size() == 0) begin
               $display("%0t: unexpected response %b", $time, got);
               error_count++;
            end else begin
               want = skel_expected.pop_front();
               if (got.skeleton_bit !== want.skeleton_bit)
                  $display("%0t: skeleton_bit expected %b actual %b", $time,
                           want.skeleton_bit, got.skeleton_bit);
               if (got.in_region !== want.in_region)
                  $display("%0t: in_region expected %b actual %b", $time,
                           want.in_region, got.in_region);
               if (got.last_pixel !== want.last_pixel)
                  $display("%0t: last_pixel expected %b actual %b", $time,
                           want.last_pixel, got.last_pixel);
               if (got !== want) error_count++;
            end
         end
         // long hold-off once so requests back up behind the stalled response
         if (!pressure_done && rsp_seen >= 80) begin
            pressure_done = 1'b1;
            rcv_hold = 600;
         end
         nready = 1'b0;
         if (rcv_hold > 0) begin
            rcv_hold--;
         end else begin
            nready = 1'b1;
            case ($urandom_range(0, 99)) inside
               [0:9]:   rcv_hold = $urandom_range(1, 4);
               [10:11]: rcv_hold = $urandom_range(20, 60);
               default: ;
            endcase
         end
         rsp_chan.ready <= nready;
      end
   end

   // watchdog on lack of progress
   int stuck_cycles;
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[DimW-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:  width_reg = value & 'h1FF;
         CSR_FRAME_HEIGHT: height_reg = value & 'h1FF;
         CSR_ROI_TOP:      top_reg = value & 'hFF;
         CSR_ROI_LEFT:     left_reg = value & 'hFF;
         CSR_ROI_BOTTOM:   bottom_reg = value & 'hFF;
         CSR_ROI_RIGHT:    right_reg = value & 'hFF;
         default: ;
      endcase
   endtask

   task automatic set_frame(input int w, input int h, input int t, input int l,
                            input int b, input int r);
      csr_write(CSR_FRAME_WIDTH, w);
      csr_write(CSR_FRAME_HEIGHT, h);
      csr_write(CSR_ROI_TOP, t);
      csr_write(CSR_ROI_LEFT, l);
      csr_write(CSR_ROI_BOTTOM, b);
      csr_write(CSR_ROI_RIGHT, r);
   endtask

   task automatic push_req(input logic kind, input logic [7:0] value);
      req_pending.push_back('{kind: kind, pixel_value: value});
      items_queued++;
   endtask

   task automatic wait_drained();
      while (req_pending.size() > 0 || req_chan.valid || skel_expected.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_pixel();
      return ($urandom_range(0, 99) < 55) ? 8'd0 : 8'($urandom_range(1, 255));
   endfunction

   // the first frame after a size change is loaded whole before any read,
   // so reads never touch unwritten pixels
   task automatic run_frames(input int frames);
      int total;
      int rd;
      total = clamp_dim(width_reg, MaxWidth) * clamp_dim(height_reg, MaxHeight);
      rd = 0;
      for (int f = 0; f < frames; f++) begin
         for (int p = 0; p < total; p++) begin
            push_req(KIND_LOAD, rand_pixel());
            if (f > 0 && $urandom_range(0, 99) < 30) begin
               push_req(KIND_READ, 8'($urandom));
               rd = (rd + 1) % total;
            end
         end
      end
      do begin
         push_req(KIND_READ, 8'($urandom));
         rd = (rd + 1) % total;
      end while (rd != 0);
      wait_drained();
   endtask

   initial begin
      logic [7:0] dir_px[9] = '{8'd0, 8'd255, 8'd0, 8'd1, 8'd0, 8'd128, 8'd0, 8'd0, 8'd127};
      int w, h;
      error_count = 0;
      items_queued = 0;
      rsp_seen = 0;
      width_reg = 256;
      height_reg = 256;
      top_reg = 1;
      left_reg = 1;
      bottom_reg = 254;
      right_reg = 254;
      load_pos = 0;
      read_pos = 0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: smallest frame, region clamped from both sides
      set_frame(3, 3, 0, 0, 255, 255);
      for (int i = 0; i < 9; i++) push_req(KIND_LOAD, dir_px[i]);
      for (int i = 0; i < 9; i++) push_req(KIND_READ, 8'hFF);
      wait_drained();

      // size saturation and extreme shapes
      set_frame(0, 0, 1, 1, 1, 1);
      run_frames(2);
      set_frame(511, 3, 0, 0, 255, 255);
      run_frames(1);
      set_frame(3, 400, 1, 1, 254, 254);
      run_frames(1);
      // empty region: nothing thinned, in_region all zero
      set_frame(6, 6, 4, 1, 2, 4);
      run_frames(2);

      while (items_queued < ITEM_TARGET) begin
         w = $urandom_range(3, 12);
         h = $urandom_range(3, 12);
         if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 2);
         set_frame(w, h, $urandom_range(0, 3), $urandom_range(0, 3),
                   ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 10),
                   ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 10));
         run_frames($urandom_range(1, 4));
      end

      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
